@@ hdl/rptw_pkg.sv @@
package rptw_pkg;

	// Table geometry. The node store holds FRAME_COUNT nodes; the frame count is a
	// power of two so that a frame number selects its node by its low bits.
	localparam int FRAME_BITS  = 6;
	localparam int FRAME_COUNT = 1 << FRAME_BITS;
	localparam int LEVELS      = 5;
	localparam int INDEX_BITS  = 9;

	// Field widths.
	localparam int CMD_W   = 2;
	localparam int VPN_W   = 45;
	localparam int PPN_W   = 45;
	localparam int ROOT_W  = 6;
	localparam int FIRST_W = 7;

	// Store address is {node, index}.
	localparam int ADDR_W      = FRAME_BITS + INDEX_BITS;
	localparam int STORE_DEPTH = FRAME_COUNT << INDEX_BITS;
	localparam int LEVEL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;

	// Allocator counter must hold FRAME_COUNT itself and any first_free_frame value.
	localparam int FREE_W = (FIRST_W > FRAME_BITS + 1) ? FIRST_W : FRAME_BITS + 1;

	// Configuration port.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = FIRST_W;
	localparam logic [CFG_INDEX_W-1:0] REG_ROOT_FRAME       = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FIRST_FREE_FRAME = 2'd1;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_MAP    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_UNMAP  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// One table entry: frame number above a valid bit.
	typedef struct packed {
		logic [PPN_W-1:0] frame;
		logic             valid;
	} entry_t;

	// Node index of a virtual page number at a given level, top field first.
	function automatic logic [INDEX_BITS-1:0] vpn_index(input logic [VPN_W-1:0] v,
		input logic [LEVEL_W-1:0] lvl);
		logic [INDEX_BITS-1:0] r;
		r = '0;
		for (int l = 0; l < LEVELS; l++) begin
			if (lvl == LEVEL_W'(l)) begin
				r = INDEX_BITS'(v >> (INDEX_BITS * (LEVELS - 1 - l)));
			end
		end
		return r;
	endfunction

endpackage

@@ hdl/radix_page_table_walker_top.sv @@
// Channel   Direction  Handshake              Payload
// request   in         in_valid / in_ready    cmd, vpn, ppn
// result    out        out_valid / out_ready  mapped, frame_out, status
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A request is accepted in the idle state, then walks one table level per step (up to five,
// one node-store read each, with a write where needed), and goes from the result state to
// the output register once that is free; the walk stops early at an invalid entry on a
// query or unmap, or when a map runs out of frames. The one read port paces the walk.
// After reset the node store is cleared, one entry a cycle, through all 32768 entries; no request
// is accepted during that pass, while configuration writes are taken at any time.
// A stalled result stays in the output register while the next request is accepted.
module radix_page_table_walker_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [rptw_pkg::CMD_W-1:0]           cmd,
	input  logic [rptw_pkg::VPN_W-1:0]           vpn,
	input  logic [rptw_pkg::PPN_W-1:0]           ppn,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 mapped,
	output logic [rptw_pkg::PPN_W-1:0]           frame_out,
	output logic                                 status,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rptw_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [rptw_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_WALK  = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]                         state_q;
	logic [rptw_pkg::ADDR_W-1:0]        clr_cnt_q;
	logic [rptw_pkg::ROOT_W-1:0]        root_frame_q;
	logic [rptw_pkg::FREE_W-1:0]        next_free_q;
	logic [rptw_pkg::LEVEL_W-1:0]       level_q;
	logic [rptw_pkg::CMD_W-1:0]         cmd_q;
	logic [rptw_pkg::VPN_W-1:0]         vpn_q;
	logic [rptw_pkg::PPN_W-1:0]         ppn_q;
	logic [rptw_pkg::ADDR_W-1:0]        walk_addr_q;
	logic                               res_mapped_q;
	logic [rptw_pkg::PPN_W-1:0]         res_frame_q;
	logic                               res_status_q;
	logic                               out_valid_q;
	logic                               out_mapped_q;
	logic [rptw_pkg::PPN_W-1:0]         out_frame_q;
	logic                               out_status_q;

	rptw_pkg::entry_t                   store_mem [rptw_pkg::STORE_DEPTH];
	rptw_pkg::entry_t                   rd_data_q;
	logic                               fwd_q;
	rptw_pkg::entry_t                   fwd_data_q;

	logic                               mem_re;
	logic [rptw_pkg::ADDR_W-1:0]        mem_raddr;
	logic                               mem_we;
	logic [rptw_pkg::ADDR_W-1:0]        mem_waddr;
	rptw_pkg::entry_t                   mem_wdata;

	rptw_pkg::entry_t                   cur_entry;
	logic                               last_level;
	logic                               walk_finish;
	logic                               walk_alloc;
	logic [rptw_pkg::PPN_W-1:0]         next_frame;
	logic                               step_mapped;
	logic [rptw_pkg::PPN_W-1:0]         step_frame;
	logic                               step_status;
	logic                               in_take;
	logic                               out_free;
	logic [rptw_pkg::LEVEL_W-1:0]       next_level;
	logic                               cfg_free_wr;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_take   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;

	// A write of first_free_frame takes precedence over an allocation in the same cycle.
	assign cfg_free_wr = cfg_valid && cfg_ready
		&& (cfg_index == rptw_pkg::REG_FIRST_FREE_FRAME);

	assign out_valid = out_valid_q;
	assign mapped    = out_mapped_q;
	assign frame_out = out_frame_q;
	assign status    = out_status_q;

	// The entry read in the previous cycle, with a same-cycle write forwarded.
	assign cur_entry  = fwd_q ? fwd_data_q : rd_data_q;
	assign last_level = (level_q == rptw_pkg::LEVEL_W'(rptw_pkg::LEVELS - 1));
	assign next_level = rptw_pkg::LEVEL_W'(level_q + 1'b1);

	// Decide one level of the walk from the entry just read.
	always_comb begin
		walk_finish = 1'b0;
		walk_alloc  = 1'b0;
		next_frame  = cur_entry.frame;
		step_mapped = 1'b0;
		step_frame  = '0;
		step_status = 1'b0;
		mem_we      = 1'b0;
		mem_waddr   = walk_addr_q;
		mem_wdata   = cur_entry;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_cnt_q;
			mem_wdata = '0;
		end else if (state_q == ST_WALK) begin
			unique case (cmd_q)
				rptw_pkg::CMD_QUERY: begin
					if (!cur_entry.valid) begin
						walk_finish = 1'b1;
					end else if (last_level) begin
						walk_finish = 1'b1;
						step_mapped = 1'b1;
						step_frame  = cur_entry.frame;
					end
				end
				rptw_pkg::CMD_MAP: begin
					if (last_level) begin
						walk_finish = 1'b1;
						mem_we      = 1'b1;
						mem_wdata   = '{frame: ppn_q, valid: 1'b1};
					end else if (!cur_entry.valid) begin
						if (next_free_q >= rptw_pkg::FREE_W'(rptw_pkg::FRAME_COUNT)) begin
							walk_finish = 1'b1;
							step_status = 1'b1;
						end else begin
							walk_alloc = 1'b1;
							next_frame = rptw_pkg::PPN_W'(next_free_q);
							mem_we     = 1'b1;
							mem_wdata  = '{frame: rptw_pkg::PPN_W'(next_free_q), valid: 1'b1};
						end
					end
				end
				rptw_pkg::CMD_UNMAP: begin
					if (last_level) begin
						walk_finish = 1'b1;
						mem_we      = 1'b1;
						mem_wdata   = '{frame: cur_entry.frame, valid: 1'b0};
					end else if (!cur_entry.valid) begin
						walk_finish = 1'b1;
					end
				end
				default: begin
					walk_finish = 1'b1;
				end
			endcase
		end
	end

	// Read address: root node at the start of a walk, the next node while walking.
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = '0;
		if (in_take) begin
			mem_re    = (cmd != rptw_pkg::CMD_UNUSED);
			mem_raddr = {rptw_pkg::FRAME_BITS'(root_frame_q),
				rptw_pkg::vpn_index(vpn, '0)};
		end else if (state_q == ST_WALK && !walk_finish) begin
			mem_re    = 1'b1;
			mem_raddr = {rptw_pkg::FRAME_BITS'(next_frame),
				rptw_pkg::vpn_index(vpn_q, next_level)};
		end
	end

	// Node store: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= store_mem[mem_raddr];
		end
	end

	// Forward a write that lands on the entry read in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else begin
			fwd_q <= mem_we && mem_re && (mem_waddr == mem_raddr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= mem_wdata;
	end

	// Sequencer, allocator and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_cnt_q    <= '0;
			root_frame_q <= '0;
			next_free_q  <= rptw_pkg::FREE_W'(1);
			level_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// In the result state the output register is reloaded below instead.
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= rptw_pkg::ADDR_W'(clr_cnt_q + 1'b1);
					if (&clr_cnt_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_take) begin
						level_q <= '0;
						state_q <= (cmd == rptw_pkg::CMD_UNUSED) ? ST_DONE : ST_WALK;
					end
				end
				ST_WALK: begin
					if (walk_alloc && !cfg_free_wr) begin
						next_free_q <= rptw_pkg::FREE_W'(next_free_q + 1'b1);
					end
					if (walk_finish) begin
						state_q <= ST_DONE;
					end else begin
						level_q <= next_level;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == rptw_pkg::REG_ROOT_FRAME) begin
					root_frame_q <= rptw_pkg::ROOT_W'(cfg_data);
				end else if (cfg_free_wr) begin
					next_free_q <= rptw_pkg::FREE_W'(cfg_data);
				end
			end
		end
	end

	// Request, walk address and result payload.
	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_q        <= cmd;
			vpn_q        <= vpn;
			ppn_q        <= ppn;
			walk_addr_q  <= mem_raddr;
			res_mapped_q <= 1'b0;
			res_frame_q  <= '0;
			res_status_q <= 1'b0;
		end else if (state_q == ST_WALK) begin
			walk_addr_q <= mem_raddr;
			if (walk_finish) begin
				res_mapped_q <= step_mapped;
				res_frame_q  <= step_frame;
				res_status_q <= step_status;
			end
		end
		if (state_q == ST_DONE && out_free) begin
			out_mapped_q <= res_mapped_q;
			out_frame_q  <= res_frame_q;
			out_status_q <= res_status_q;
		end
	end

endmodule

@@ hdl/rptw_checker.sv @@
module rptw_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_ready,
	input  logic [rptw_pkg::CMD_W-1:0]           cmd,
	input  logic [rptw_pkg::VPN_W-1:0]           vpn,
	input  logic [rptw_pkg::PPN_W-1:0]           ppn,
	input  logic                                 out_valid,
	input  logic                                 out_ready,
	input  logic                                 mapped,
	input  logic [rptw_pkg::PPN_W-1:0]           frame_out,
	input  logic                                 status
);

	// A waiting request keeps its payload until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(cmd) && $stable(vpn) && $stable(ppn))
		else $error("request changed while waiting");

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mapped) && $stable(frame_out)
			&& $stable(status))
		else $error("result changed while stalled");

	// Only a map can run out of frames, and only a query reports a mapping.
	a_status_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> !mapped)
		else $error("exhausted result also reports a mapping");

	// Without a mapping the frame output is zero.
	a_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !mapped |-> frame_out == '0)
		else $error("frame output set without a mapping");

	// One request at a time: the walker is busy after taking a request.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while a walk is in progress");

endmodule

bind radix_page_table_walker_top rptw_checker u_rptw_checker (.*);
